[rtl/rv32seu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32seu_pkg
// Shared types, codes and the instruction decoder of the RV32 subset
// execute unit.
// ----------------------------------------------------------------------------
package rv32seu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);

  localparam logic [XLEN-1:0] STACK_TOP_RESET = 32'd2465792;

  // Major opcodes and fixed system words
  localparam logic [6:0]      OPC_IMM   = 7'h13;
  localparam logic [6:0]      OPC_LUI   = 7'h37;
  localparam logic [6:0]      OPC_AUIPC = 7'h17;
  localparam logic [6:0]      OPC_REG   = 7'h33;
  localparam logic [6:0]      F7_MULDIV = 7'h01;
  localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [XLEN-1:0] UPPER_MASK  = 32'hFFFF_F000;

  // funct3 codes of the M extension and of ADDI
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_REMU = 3'd7;
  localparam logic [2:0] F3_ADDI = 3'd0;

  // Architectural register indexes with a fixed role
  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_SP   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd10;
  localparam logic [REG_AW-1:0] REG_A1   = 5'd11;
  localparam logic [REG_AW-1:0] REG_A2   = 5'd12;
  localparam logic [REG_AW-1:0] REG_A7   = 5'd17;

  // Configuration register indexes
  localparam logic CFG_STACK_TOP = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ILLEGAL = 2'd1,
    STAT_ECALL   = 2'd2,
    STAT_EBREAK  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_ADDI,
    OP_LUI,
    OP_AUIPC,
    OP_MUL,
    OP_MULH,
    OP_DIV,
    OP_DIVU,
    OP_REM,
    OP_REMU,
    OP_ECALL,
    OP_EBREAK,
    OP_ILLEGAL
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SETUP,
    S_WAIT,
    S_FIN
  } exec_state_e;

  typedef enum logic [1:0] {
    MDU_IDLE,
    MDU_RUN,
    MDU_FIX
  } mdu_state_e;

  // Request into the multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_mul;
    logic high;
    logic sgn;
    logic rem;
  } mdu_req_t;

  function automatic op_e decode_op(input logic [XLEN-1:0] w);
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
    op_e        op;
    opcode = w[6:0];
    f3     = w[14:12];
    f7     = w[31:25];
    op     = OP_ILLEGAL;
    priority if (opcode == OPC_IMM) begin
      op = (f3 == F3_ADDI) ? OP_ADDI : OP_ILLEGAL;
    end else if (opcode == OPC_LUI) begin
      op = OP_LUI;
    end else if (opcode == OPC_AUIPC) begin
      op = OP_AUIPC;
    end else if (opcode == OPC_REG && f7 == F7_MULDIV) begin
      unique case (f3)
        F3_MUL:  op = OP_MUL;
        F3_MULH: op = OP_MULH;
        F3_DIV:  op = OP_DIV;
        F3_DIVU: op = OP_DIVU;
        F3_REM:  op = OP_REM;
        F3_REMU: op = OP_REMU;
        default: op = OP_ILLEGAL;
      endcase
    end else if (w == WORD_ECALL) begin
      op = OP_ECALL;
    end else if (w == WORD_EBREAK) begin
      op = OP_EBREAK;
    end else begin
      op = OP_ILLEGAL;
    end
    return op;
  endfunction

endpackage
`default_nettype wire

[rtl/rv32_subset_execute_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_subset_execute_unit
// Executes one RV32 instruction word per item against its own register file
// and program counter: ADDI, LUI, AUIPC, MUL, MULH, DIV, DIVU, REM, REMU,
// with ECALL / EBREAK reporting and illegal-encoding flagging.
// ----------------------------------------------------------------------------
// The unit takes one instruction item at a time and returns one result item
// for it. After an item is accepted, in_stall_o stays high until the result is
// loaded into the output register. The register file is a single-read-port
// memory, so every item reads its operands one at a time (rs1, rs2, or a7,
// a0, a1, a2 for ECALL), then passes through setup and a retire state. ADDI,
// LUI, AUIPC, system and illegal words are finished in setup. The M
// instructions go through the shared iterative multiply/divide unit at one
// bit per cycle, 32 steps plus start and fix-up. A finished result waits in
// the output register while the next item is taken. x0 reads zero and is
// never written; x2 reads the stack_top register until the program writes
// it. Writing stack_top over APB (address 0) loads x2 again at once. The
// program counter starts at 0 and moves by 4 per item, legal or not; each
// result reports the address of its instruction.
// ----------------------------------------------------------------------------
module rv32_subset_execute_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  // instruction channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] instr_word_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic        write_enable_o,
  output logic [4:0]  dest_reg_o,
  output logic [31:0] write_value_o,
  output logic [31:0] instr_addr_o,
  output logic [31:0] call_number_o,
  output logic [31:0] call_arg0_o,
  output logic [31:0] call_arg1_o,
  output logic [31:0] call_arg2_o,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned XL = rv32seu_pkg::XLEN;
  localparam int unsigned AW = rv32seu_pkg::REG_AW;
  localparam int unsigned NR = rv32seu_pkg::NUM_REGS;
  localparam logic [1:0]  RD_LAST = 2'd3;

  rv32seu_pkg::exec_state_e state_q, state_d;

  // Item context
  logic [XL-1:0] instr_q, pc_q, iaddr_q;
  rv32seu_pkg::op_e op;
  logic [AW-1:0] rd, rs1, rs2;

  // Register file: memory plus a valid bit per entry; invalid reads the reset
  // value (stack_top for x2, zero elsewhere)
  logic [XL-1:0] mem [NR];
  logic [NR-1:0] valid_q;
  logic [XL-1:0] stack_top_q;

  // Operand read sequencer
  logic [1:0]    rd_cnt_q;
  logic [AW-1:0] raddr;
  logic          rd_pend_q, rd_hit_q;
  logic [1:0]    rd_slot_q;
  logic [XL-1:0] rdata_q, rd_dflt_q;
  logic [XL-1:0] opnd_q [4];

  logic [XL-1:0] val_q, val_d;
  logic          writes, is_m, in_fire, fin_fire, cfg_wr;
  rv32seu_pkg::mdu_req_t mdu_req;
  logic          mdu_done;
  logic [XL-1:0] mdu_result;

  // Output register
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic          we_q;
  logic [AW-1:0] dest_q;
  logic [XL-1:0] wval_q, oaddr_q, cn_q, c0_q, c1_q, c2_q;
  rv32seu_pkg::status_e status_d;

  // Decode the held word
  always_comb begin
    op  = rv32seu_pkg::decode_op(instr_q);
    rd  = instr_q[11:7];
    rs1 = instr_q[19:15];
    rs2 = instr_q[24:20];
    is_m = (op == rv32seu_pkg::OP_MUL)  || (op == rv32seu_pkg::OP_MULH) ||
           (op == rv32seu_pkg::OP_DIV)  || (op == rv32seu_pkg::OP_DIVU) ||
           (op == rv32seu_pkg::OP_REM)  || (op == rv32seu_pkg::OP_REMU);
    writes = is_m || (op == rv32seu_pkg::OP_ADDI) || (op == rv32seu_pkg::OP_LUI) ||
             (op == rv32seu_pkg::OP_AUIPC);
  end

  // APB: single register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == rv32seu_pkg::CFG_STACK_TOP);
  assign prdata = (paddr[2] == rv32seu_pkg::CFG_STACK_TOP) ? stack_top_q : '0;

  assign in_stall_o = (state_q != rv32seu_pkg::S_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign fin_fire   = (state_q == rv32seu_pkg::S_FIN) & ~(out_valid_q & out_stall_i);

  // Read address: ECALL pulls a7, a0, a1, a2; everything else rs1, rs2
  always_comb begin
    if (op == rv32seu_pkg::OP_ECALL) begin
      unique case (rd_cnt_q)
        2'd0:    raddr = rv32seu_pkg::REG_A7;
        2'd1:    raddr = rv32seu_pkg::REG_A0;
        2'd2:    raddr = rv32seu_pkg::REG_A1;
        default: raddr = rv32seu_pkg::REG_A2;
      endcase
    end else begin
      raddr = rd_cnt_q[0] ? rs2 : rs1;
    end
  end

  // Multiply / divide request, issued from setup
  always_comb begin
    mdu_req.start  = (state_q == rv32seu_pkg::S_SETUP) & is_m;
    mdu_req.is_mul = (op == rv32seu_pkg::OP_MUL) || (op == rv32seu_pkg::OP_MULH);
    mdu_req.high   = (op == rv32seu_pkg::OP_MULH);
    mdu_req.sgn    = (op == rv32seu_pkg::OP_MULH) || (op == rv32seu_pkg::OP_DIV) ||
                     (op == rv32seu_pkg::OP_REM);
    mdu_req.rem    = (op == rv32seu_pkg::OP_REM) || (op == rv32seu_pkg::OP_REMU);
  end

  rv32seu_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mdu_req),
    .opa_i    (opnd_q[0]),
    .opb_i    (opnd_q[1]),
    .done_o   (mdu_done),
    .result_o (mdu_result)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    unique case (state_q)
      rv32seu_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = rv32seu_pkg::S_READ;
        end
      end
      rv32seu_pkg::S_READ: begin
        if (rd_cnt_q == RD_LAST) begin
          state_d = rv32seu_pkg::S_SETUP;
        end
      end
      rv32seu_pkg::S_SETUP: begin
        // Simple ops finish here; M ops hand off to the shared unit
        unique case (op)
          rv32seu_pkg::OP_ADDI:
            val_d = opnd_q[0] + {{20{instr_q[31]}}, instr_q[31:20]};
          rv32seu_pkg::OP_LUI:
            val_d = instr_q & rv32seu_pkg::UPPER_MASK;
          rv32seu_pkg::OP_AUIPC:
            val_d = iaddr_q + (instr_q & rv32seu_pkg::UPPER_MASK);
          default:
            val_d = '0;
        endcase
        state_d = is_m ? rv32seu_pkg::S_WAIT : rv32seu_pkg::S_FIN;
      end
      rv32seu_pkg::S_WAIT: begin
        if (mdu_done) begin
          val_d   = mdu_result;
          state_d = rv32seu_pkg::S_FIN;
        end
      end
      rv32seu_pkg::S_FIN: begin
        // Hold until the output register is free
        if (fin_fire) begin
          state_d = rv32seu_pkg::S_IDLE;
        end
      end
      default: state_d = rv32seu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    unique case (op)
      rv32seu_pkg::OP_ILLEGAL: status_d = rv32seu_pkg::STAT_ILLEGAL;
      rv32seu_pkg::OP_ECALL:   status_d = rv32seu_pkg::STAT_ECALL;
      rv32seu_pkg::OP_EBREAK:  status_d = rv32seu_pkg::STAT_EBREAK;
      default:                 status_d = rv32seu_pkg::STAT_OK;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rv32seu_pkg::S_IDLE;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      stack_top_q <= rv32seu_pkg::STACK_TOP_RESET;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == rv32seu_pkg::S_READ);
      if (state_q == rv32seu_pkg::S_READ) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else begin
        rd_cnt_q <= '0;
      end
      if (in_fire) begin
        pc_q <= pc_q + 32'd4;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_fire && writes && rd != rv32seu_pkg::REG_ZERO) begin
        valid_q[rd] <= 1'b1;
      end
      // New stack top: drop any program write to x2
      if (cfg_wr) begin
        stack_top_q                  <= pwdata;
        valid_q[rv32seu_pkg::REG_SP] <= 1'b0;
      end
    end
  end

  // Register file memory
  always_ff @(posedge clk_i) begin
    if (fin_fire && writes && rd != rv32seu_pkg::REG_ZERO) begin
      mem[rd] <= val_q;
    end
    if (state_q == rv32seu_pkg::S_READ) begin
      rdata_q <= mem[raddr];
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      instr_q <= instr_word_i;
      iaddr_q <= pc_q;
    end
    if (state_q == rv32seu_pkg::S_READ) begin
      rd_slot_q <= rd_cnt_q;
      rd_hit_q  <= valid_q[raddr];
      rd_dflt_q <= (raddr == rv32seu_pkg::REG_SP) ? stack_top_q : '0;
    end
    if (rd_pend_q) begin
      opnd_q[rd_slot_q] <= rd_hit_q ? rdata_q : rd_dflt_q;
    end
    val_q <= val_d;
    if (fin_fire) begin
      status_q <= status_d;
      oaddr_q  <= iaddr_q;
      if (writes && rd != rv32seu_pkg::REG_ZERO) begin
        we_q   <= 1'b1;
        dest_q <= rd;
        wval_q <= val_q;
      end else begin
        we_q   <= 1'b0;
        dest_q <= '0;
        wval_q <= '0;
      end
      if (op == rv32seu_pkg::OP_ECALL) begin
        cn_q <= opnd_q[0];
        c0_q <= opnd_q[1];
        c1_q <= opnd_q[2];
        c2_q <= opnd_q[3];
      end else begin
        cn_q <= '0;
        c0_q <= '0;
        c1_q <= '0;
        c2_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign write_enable_o = we_q;
  assign dest_reg_o     = dest_q;
  assign write_value_o  = wval_q;
  assign instr_addr_o   = oaddr_q;
  assign call_number_o  = cn_q;
  assign call_arg0_o    = c0_q;
  assign call_arg1_o    = c1_q;
  assign call_arg2_o    = c2_q;

endmodule
`default_nettype wire

[rtl/rv32seu_mdu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32seu_mdu
// Iterative multiply / divide unit: one shared 33-bit adder, one bit per
// cycle over 32 steps, then a sign fix-up state that raises done.
// ----------------------------------------------------------------------------
module rv32seu_mdu (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire rv32seu_pkg::mdu_req_t       req_i,
  input  wire [rv32seu_pkg::XLEN-1:0]      opa_i,
  input  wire [rv32seu_pkg::XLEN-1:0]      opb_i,
  output logic                             done_o,
  output logic [rv32seu_pkg::XLEN-1:0]     result_o
);

  localparam int unsigned CW = $clog2(rv32seu_pkg::XLEN);
  localparam logic [CW-1:0] CNT_LAST = CW'(rv32seu_pkg::XLEN - 1);

  rv32seu_pkg::mdu_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // hi: running product high half or partial remainder
  // lo: multiplier or dividend shifting out, quotient / product low shifting in
  logic [rv32seu_pkg::XLEN-1:0] hi_q, hi_d, lo_q, lo_d, dvs_q, dvs_d;
  logic mul_q, mul_d, high_q, high_d, rem_q, rem_d, neg_q, neg_d;

  logic                         sa, sb;
  logic [rv32seu_pkg::XLEN-1:0] mag_a, mag_b, raw;
  logic                         inc;
  logic [rv32seu_pkg::XLEN:0]   add_x, add_y;
  logic                         add_cin;
  logic [rv32seu_pkg::XLEN+1:0] add_sum;
  logic                         ge;

  always_comb begin
    sa    = req_i.sgn & opa_i[rv32seu_pkg::XLEN-1];
    sb    = req_i.sgn & opb_i[rv32seu_pkg::XLEN-1];
    mag_a = sa ? (~opa_i + 32'd1) : opa_i;
    mag_b = sb ? (~opb_i + 32'd1) : opb_i;
  end

  // Shared adder: add for multiply, trial subtract for divide
  always_comb begin
    if (mul_q) begin
      add_x   = {1'b0, hi_q};
      add_y   = {1'b0, (lo_q[0] ? dvs_q : '0)};
      add_cin = 1'b0;
    end else begin
      add_x   = {hi_q, lo_q[rv32seu_pkg::XLEN-1]};
      add_y   = ~{1'b0, dvs_q};
      add_cin = 1'b1;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(rv32seu_pkg::XLEN+1){1'b0}}, add_cin};
    ge      = add_sum[rv32seu_pkg::XLEN+1];
  end

  // Fix-up: pick the half and negate where the signs call for it
  always_comb begin
    if (mul_q) begin
      raw = high_q ? hi_q : lo_q;
      inc = high_q ? (lo_q == '0) : 1'b1;
    end else begin
      raw = rem_q ? hi_q : lo_q;
      inc = 1'b1;
    end
    result_o = neg_q ? (~raw + {{(rv32seu_pkg::XLEN-1){1'b0}}, inc}) : raw;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    dvs_d   = dvs_q;
    mul_d   = mul_q;
    high_d  = high_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    done_o  = 1'b0;
    unique case (state_q)
      rv32seu_pkg::MDU_IDLE: begin
        if (req_i.start) begin
          hi_d   = '0;
          lo_d   = mag_a;
          dvs_d  = mag_b;
          mul_d  = req_i.is_mul;
          high_d = req_i.high;
          rem_d  = req_i.rem;
          // Quotient by zero stays all ones; remainder follows the dividend
          if (req_i.is_mul) begin
            neg_d = sa ^ sb;
          end else if (req_i.rem) begin
            neg_d = sa;
          end else begin
            neg_d = (sa ^ sb) & (opb_i != '0);
          end
          cnt_d   = '0;
          state_d = rv32seu_pkg::MDU_RUN;
        end
      end
      rv32seu_pkg::MDU_RUN: begin
        if (mul_q) begin
          hi_d = add_sum[rv32seu_pkg::XLEN:1];
          lo_d = {add_sum[0], lo_q[rv32seu_pkg::XLEN-1:1]};
        end else begin
          hi_d = ge ? add_sum[rv32seu_pkg::XLEN-1:0]
                    : {hi_q[rv32seu_pkg::XLEN-2:0], lo_q[rv32seu_pkg::XLEN-1]};
          lo_d = {lo_q[rv32seu_pkg::XLEN-2:0], ge};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = rv32seu_pkg::MDU_FIX;
        end
      end
      rv32seu_pkg::MDU_FIX: begin
        done_o  = 1'b1;
        state_d = rv32seu_pkg::MDU_IDLE;
      end
      default: state_d = rv32seu_pkg::MDU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rv32seu_pkg::MDU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    dvs_q  <= dvs_d;
    mul_q  <= mul_d;
    high_q <= high_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

endmodule
`default_nettype wire

[test/rv32_subset_execute_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_execute_unit_tb
// Self-checking bench for the RV32 subset execute unit. It feeds instruction
// items through the valid/stall channel and checks every result item against
// its own model of the register file and program counter. The stack_top
// register is reloaded over APB between phases. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module rv32_subset_execute_unit_tb;
  import rv32seu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CHUNK_ITEMS  = 205;
  localparam int unsigned NUM_PHASES   = 5;

  // Encodings the package does not name
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [2:0] F3_MULHSU  = 3'd2;
  localparam logic [2:0] F3_MULHU   = 3'd3;
  localparam logic [2:0] F3_SLLI    = 3'd1;
  localparam logic [6:0] F7_BASE    = 7'h00;

  // Register byte address on the APB port
  localparam logic [2:0] STACK_TOP_ADDR = 3'(CFG_STACK_TOP) << 2;

  // One result item as the unit reports it
  typedef struct packed {
    status_e     status;
    logic        we;
    logic [4:0]  rd;
    logic [31:0] value;
    logic [31:0] addr;
    logic [31:0] cn;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
  } retire_t;

  // Architectural model of the unit plus the queue of retires still owed
  class retire_scoreboard;
    bit [31:0] regs [32];
    bit [31:0] pc;
    bit [31:0] stack_top;
    retire_t   expected_retires [$];
    int        mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      stack_top      = STACK_TOP_RESET;
      regs[REG_SP]   = stack_top;
      pc             = '0;
      mismatches     = 0;
    endfunction

    function void load_stack_top(bit [31:0] v);
      stack_top    = v;
      regs[REG_SP] = v;
    endfunction

    function bit [31:0] divide(bit [31:0] a, bit [31:0] b, bit sgn, bit want_rem);
      bit [31:0] ua, ub, q, r;
      if (b == '0) return want_rem ? a : '1;
      if (!sgn) return want_rem ? a % b : a / b;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q  = ua / ub;
      r  = ua % ub;
      if (a[31] != b[31]) q = -q;
      if (a[31]) r = -r;
      return want_rem ? r : q;
    endfunction

    // Execute one accepted instruction and queue the result it must produce
    function void execute_instr(bit [31:0] w);
      bit [6:0]         opc, f7;
      bit [4:0]         rd, rs1, rs2;
      bit [2:0]         f3;
      bit [31:0]        a, b, value;
      bit               writes;
      bit signed [63:0] ext_a, ext_b, prod;
      retire_t          e;
      opc    = w[6:0];
      rd     = w[11:7];
      f3     = w[14:12];
      rs1    = w[19:15];
      rs2    = w[24:20];
      f7     = w[31:25];
      a      = regs[rs1];
      b      = regs[rs2];
      e      = '0;
      e.addr = pc;
      value  = '0;
      writes = 1'b0;
      if (opc == OPC_IMM) begin
        if (f3 == F3_ADDI) begin
          value  = a + {{20{w[31]}}, w[31:20]};
          writes = 1'b1;
        end else begin
          e.status = STAT_ILLEGAL;
        end
      end else if (opc == OPC_LUI) begin
        value  = w & UPPER_MASK;
        writes = 1'b1;
      end else if (opc == OPC_AUIPC) begin
        value  = pc + (w & UPPER_MASK);
        writes = 1'b1;
      end else if (opc == OPC_REG && f7 == F7_MULDIV) begin
        writes = 1'b1;
        case (f3)
          F3_MUL:  value = a * b;
          F3_MULH: begin
            ext_a = {{32{a[31]}}, a};
            ext_b = {{32{b[31]}}, b};
            prod  = ext_a * ext_b;
            value = prod[63:32];
          end
          F3_DIV:  value = divide(a, b, 1'b1, 1'b0);
          F3_DIVU: value = divide(a, b, 1'b0, 1'b0);
          F3_REM:  value = divide(a, b, 1'b1, 1'b1);
          F3_REMU: value = divide(a, b, 1'b0, 1'b1);
          default: begin
            writes   = 1'b0;
            e.status = STAT_ILLEGAL;
          end
        endcase
      end else if (w == WORD_ECALL) begin
        e.status = STAT_ECALL;
        e.cn     = regs[REG_A7];
        e.c0     = regs[REG_A0];
        e.c1     = regs[REG_A1];
        e.c2     = regs[REG_A2];
      end else if (w == WORD_EBREAK) begin
        e.status = STAT_EBREAK;
      end else begin
        e.status = STAT_ILLEGAL;
      end
      if (writes && rd != REG_ZERO) begin
        regs[rd] = value;
        e.we     = 1'b1;
        e.rd     = rd;
        e.value  = value;
      end
      pc = pc + 32'd4;
      expected_retires.push_back(e);
    endfunction

    function void check_retire(retire_t got);
      retire_t exp;
      bit      bad;
      if (expected_retires.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: pc %h status %0d", got.addr, got.status);
        return;
      end
      exp = expected_retires.pop_front();
      bad = (exp.status != got.status) || (exp.we != got.we) || (exp.rd != got.rd) ||
            (exp.value != got.value) || (exp.addr != got.addr) || (exp.cn != got.cn) ||
            (exp.c0 != got.c0) || (exp.c1 != got.c1) || (exp.c2 != got.c2);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch pc %h exp: st=%0d we=%0b rd=%0d val=%h addr=%h a7=%h a0=%h a1=%h a2=%h",
                   exp.addr, exp.status, exp.we, exp.rd, exp.value, exp.addr,
                   exp.cn, exp.c0, exp.c1, exp.c2);
          $display("             got: st=%0d we=%0b rd=%0d val=%h addr=%h a7=%h a0=%h a1=%h a2=%h",
                   got.status, got.we, got.rd, got.value, got.addr,
                   got.cn, got.c0, got.c1, got.c2);
        end
      end
    endfunction
  endclass

  // Clock, reset and the unit's inputs, all known from time zero
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [31:0] instr_word_i = '0;
  logic        out_stall_i  = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic        write_enable_o;
  logic [4:0]  dest_reg_o;
  logic [31:0] write_value_o;
  logic [31:0] instr_addr_o;
  logic [31:0] call_number_o;
  logic [31:0] call_arg0_o;
  logic [31:0] call_arg1_o;
  logic [31:0] call_arg2_o;
  logic [31:0] prdata;
  logic        pready;

  retire_scoreboard sb;
  bit [31:0]        stim_q [$];
  bit               idle_on = 1'b1;
  int unsigned      cycle_count = 0;

  rv32_subset_execute_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instr_word_i   (instr_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .write_enable_o (write_enable_o),
    .dest_reg_o     (dest_reg_o),
    .write_value_o  (write_value_o),
    .instr_addr_o   (instr_addr_o),
    .call_number_o  (call_number_o),
    .call_arg0_o    (call_arg0_o),
    .call_arg1_o    (call_arg1_o),
    .call_arg2_o    (call_arg2_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Gap length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias register picks toward a small working set and the ecall registers
  function automatic bit [4:0] pick_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return REG_ZERO;
    if (r < 55) return 5'($urandom_range(1, 8));
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return REG_A0;
        1:       return REG_A1;
        2:       return REG_A2;
        default: return REG_A7;
      endcase
    end
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic bit [11:0] pick_imm12();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'h7FF;
      2:       return 12'h800;
      3:       return 12'hFFF;
      4:       return 12'h001;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic bit [19:0] pick_imm20();
    case ($urandom_range(0, 6))
      0:       return 20'h80000;
      1:       return 20'hFFFFF;
      2:       return 20'h00000;
      3:       return 20'h7FFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic bit [2:0] pick_muldiv_f3();
    case ($urandom_range(0, 5))
      0:       return F3_MUL;
      1:       return F3_MULH;
      2:       return F3_DIV;
      3:       return F3_DIVU;
      4:       return F3_REM;
      default: return F3_REMU;
    endcase
  endfunction

  function automatic bit [31:0] enc_addi(bit [4:0] rd, bit [4:0] rs1, bit [11:0] imm);
    return {imm, rs1, F3_ADDI, rd, OPC_IMM};
  endfunction

  function automatic bit [31:0] enc_upper(bit [6:0] opc, bit [4:0] rd, bit [19:0] imm);
    return {imm, rd, opc};
  endfunction

  function automatic bit [31:0] enc_muldiv(bit [2:0] f3, bit [4:0] rd, bit [4:0] rs1,
                                           bit [4:0] rs2);
    return {F7_MULDIV, rs2, rs1, f3, rd, OPC_REG};
  endfunction

  // Broken or unsupported encodings, plus fully random words
  function automatic bit [31:0] pick_noise();
    bit [31:0] w;
    bit [6:0]  f7;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: ;
      1: w = {w[31:15], 3'($urandom_range(1, 7)), w[11:7], OPC_IMM};
      2: begin
        f7 = w[31:25];
        if (f7 == F7_MULDIV) f7 = F7_BASE;
        w = {f7, w[24:7], OPC_REG};
      end
      3: w = {F7_MULDIV, w[24:15], ($urandom_range(0, 1) ? F3_MULHSU : F3_MULHU), w[11:7],
              OPC_REG};
      4: w = {w[31:7], OPC_SYSTEM};
      default: w = ($urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK) ^
                   (32'd1 << $urandom_range(7, 31));
    endcase
    return w;
  endfunction

  // Queue one phase of random items: mostly well-formed programs
  function automatic void fill_chunk(int n);
    int       r;
    bit [4:0] ra, rb;
    while (stim_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        stim_q.push_back(enc_addi(pick_reg(), pick_reg(), pick_imm12()));
      end else if (r < 25) begin
        stim_q.push_back(enc_upper(OPC_LUI, pick_reg(), pick_imm20()));
      end else if (r < 30) begin
        stim_q.push_back(enc_upper(OPC_AUIPC, pick_reg(), pick_imm20()));
      end else if (r < 65) begin
        stim_q.push_back(enc_muldiv(pick_muldiv_f3(), pick_reg(), pick_reg(), pick_reg()));
      end else if (r < 70) begin
        // Signed overflow: most negative value divided by minus one
        ra = 5'($urandom_range(1, 31));
        rb = 5'($urandom_range(1, 31));
        if (rb == ra) rb = ra ^ 5'd1;
        if (rb == REG_ZERO) rb = 5'd1;
        stim_q.push_back(enc_upper(OPC_LUI, ra, 20'h80000));
        stim_q.push_back(enc_addi(rb, REG_ZERO, 12'hFFF));
        stim_q.push_back(enc_muldiv(($urandom_range(0, 1) ? F3_DIV : F3_REM), pick_reg(),
                                    ra, rb));
      end else if (r < 77) begin
        stim_q.push_back(WORD_ECALL);
      end else if (r < 81) begin
        stim_q.push_back(WORD_EBREAK);
      end else begin
        stim_q.push_back(pick_noise());
      end
    end
  endfunction

  // Send every queued item; keep valid up across back-to-back items and
  // drop it only for a gap or at the end of the burst
  task automatic drive_burst();
    bit [31:0] w;
    int        gap;
    while (stim_q.size() != 0) begin
      w   = stim_q.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i   <= 1'b1;
      instr_word_i <= w;
      do @(posedge clk_i); while (in_stall_o);
      sb.execute_instr(w);
    end
    in_valid_i <= 1'b0;
  endtask

  // Hold the sender until every owed result item has come back
  task automatic wait_drained();
    while (sb.expected_retires.size() != 0) @(posedge clk_i);
  endtask

  // Read stack_top and compare with the model's copy
  task automatic readback_stack_top();
    bit [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= STACK_TOP_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.stack_top) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("stack_top readback: exp %h got %h", sb.stack_top, got);
    end
  endtask

  // Write stack_top (setup then access), then read it straight back
  task automatic write_stack_top(bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STACK_TOP_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.load_stack_top(v);
    readback_stack_top();
  endtask

  // Result side: check each accepted item, then pick the next stall
  initial begin
    retire_t got;
    int      stall_left;
    int      len;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = status_e'(status_o);
        got.we     = write_enable_o;
        got.rd     = dest_reg_o;
        got.value  = write_value_o;
        got.addr   = instr_addr_o;
        got.cn     = call_number_o;
        got.c0     = call_arg0_o;
        got.c1     = call_arg1_o;
        got.c2     = call_arg2_o;
        sb.check_retire(got);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        len = pick_gap();
        out_stall_i <= (len > 0);
        stall_left  = (len > 0) ? len - 1 : 0;
      end
    end
  end

  // Main sequence
  initial begin
    bit [31:0] cfg_value;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the reset value of stack_top before anything else touches it
    readback_stack_top();

    // Directed: field extremes, every operation, the corner cases
    stim_q.push_back(enc_addi(5'd1, REG_SP, 12'h000));       // x2 holds stack_top
    stim_q.push_back(enc_addi(5'd5, REG_ZERO, 12'h7FF));     // largest immediate
    stim_q.push_back(enc_addi(5'd6, REG_ZERO, 12'h800));     // most negative immediate
    stim_q.push_back(enc_addi(5'd7, REG_ZERO, 12'hFFF));     // minus one
    stim_q.push_back(enc_upper(OPC_LUI, 5'd8, 20'h80000));
    stim_q.push_back(enc_upper(OPC_LUI, 5'd9, 20'hFFFFF));
    stim_q.push_back(enc_upper(OPC_AUIPC, 5'd3, 20'h00001));
    stim_q.push_back(enc_upper(OPC_AUIPC, 5'd4, 20'hFFFFF)); // address wraps
    stim_q.push_back(enc_addi(REG_ZERO, 5'd5, 12'h001));     // write to x0 dropped
    stim_q.push_back(enc_muldiv(F3_MUL, REG_A0, 5'd8, 5'd7));
    stim_q.push_back(enc_muldiv(F3_MULH, REG_A1, 5'd8, 5'd8));
    stim_q.push_back(enc_muldiv(F3_MULH, REG_A2, 5'd7, 5'd5));
    stim_q.push_back(enc_muldiv(F3_DIV, 5'd13, 5'd8, 5'd7));  // signed overflow
    stim_q.push_back(enc_muldiv(F3_REM, 5'd14, 5'd8, 5'd7));  // signed overflow
    stim_q.push_back(enc_muldiv(F3_DIV, 5'd15, 5'd5, REG_ZERO));   // divide by zero
    stim_q.push_back(enc_muldiv(F3_DIVU, 5'd16, 5'd9, REG_ZERO));
    stim_q.push_back(enc_muldiv(F3_REM, REG_A7, 5'd6, REG_ZERO));
    stim_q.push_back(enc_muldiv(F3_REMU, 5'd18, 5'd7, 5'd5));
    stim_q.push_back(enc_muldiv(F3_DIV, 5'd20, 5'd6, 5'd5));  // mixed signs
    stim_q.push_back(WORD_ECALL);
    stim_q.push_back(WORD_EBREAK);
    stim_q.push_back({12'h001, 5'd1, F3_SLLI, 5'd1, OPC_IMM});               // bad funct3
    stim_q.push_back({F7_BASE, 5'd2, 5'd1, F3_MUL, 5'd3, OPC_REG});          // plain ADD
    stim_q.push_back({F7_MULDIV, 5'd2, 5'd1, F3_MULHSU, 5'd3, OPC_REG});     // MULHSU
    stim_q.push_back({12'h002, REG_ZERO, 3'd0, REG_ZERO, OPC_SYSTEM});      // other system
    stim_q.push_back(32'hFFFF_FFFF);
    drive_burst();
    wait_drained();

    // Random phases; reload stack_top between them while the unit is idle.
    // Phase two runs with no gaps or stalls at all.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       cfg_value = 32'h0000_0000;
          2:       cfg_value = 32'hFFFF_FFFF;
          3:       cfg_value = $urandom;
          default: cfg_value = 32'h8000_0000;
        endcase
        write_stack_top(cfg_value);
      end
      idle_on = (phase != 2);
      fill_chunk(CHUNK_ITEMS);
      drive_burst();
      wait_drained();
    end

    // Let any stray result item surface before deciding
    idle_on = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_retires.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
